// ===== rtl/core/moving_point_circle_hit_time_assert.svh =====
// Assertion helpers used by the top-level RTL; clock and reset are aclk / aresetn.
`ifndef MOVING_POINT_CIRCLE_HIT_TIME_ASSERT_SVH
`define MOVING_POINT_CIRCLE_HIT_TIME_ASSERT_SVH

// Implication checked while out of reset.
`define MPCH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked at every edge, reset included.
`define MPCH_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/mpch_pkg.sv =====
`default_nettype none
package mpch_pkg;

    localparam int COORD_W   = 24;
    localparam int RAD_W     = COORD_W - 1;
    localparam int MAG_W     = COORD_W;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int HALF_W    = PROD_W / 2;
    localparam int WIDE_W    = 2 * PROD_W;
    localparam int ROOT_W    = WIDE_W / 2;
    localparam int SQREM_W   = ROOT_W + 2;
    localparam int NUM_W     = ROOT_W + 1;
    localparam int TIME_FRAC = 16;
    localparam int TIME_W    = 32;
    localparam int SQ_CELLS  = ROOT_W;
    localparam int DIV_CELLS = TIME_W;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_ZERO_VEL = 3'd1,
        ST_BEHIND   = 3'd2,
        ST_NO_ROOT  = 3'd3,
        ST_NO_POS   = 3'd4
    } status_t;

    // word moving through the square-root cells
    typedef struct packed {
        logic                done;
        status_t             status;
        logic                hneg;
        logic [PROD_W-1:0]   hm;
        logic [PROD_W-1:0]   a;
        logic [WIDE_W-1:0]   disc;
        logic [SQREM_W-1:0]  rem;
        logic [ROOT_W-1:0]   root;
    } sq_t;

    // word moving through the divider cells
    typedef struct packed {
        logic                done;
        status_t             status;
        logic                sat;
        logic [PROD_W-1:0]   a;
        logic [TIME_W-1:0]   bits;
        logic [PROD_W-1:0]   rem;
        logic [TIME_W-1:0]   quot;
    } dv_t;

endpackage
`default_nettype wire

// ===== rtl/core/mpch_front.sv =====
`default_nettype none
module mpch_front import mpch_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_vld,
    input  wire logic [COORD_W-1:0] dx,
    input  wire logic [COORD_W-1:0] dy,
    input  wire logic [COORD_W-1:0] vx,
    input  wire logic [COORD_W-1:0] vy,
    input  wire logic [RAD_W-1:0]   radius,
    output logic                    out_vld,
    output sq_t                     out_word
);

    function automatic logic [MAG_W-1:0] mag(input logic [COORD_W-1:0] x);
        mag = x[COORD_W-1] ? (~x + 1'b1) : x;
    endfunction

    logic [MAG_W-1:0] mdx, mdy, mvx, mvy;
    logic [2*RAD_W-1:0] rr_prod;
    logic [3:0] vld_reg;

    // stage 1: squares and cross products
    logic [PROD_W-1:0] vx2_reg, vy2_reg, dx2_reg, dy2_reg, rr_reg, px_reg, py_reg;
    logic pxn_reg, pyn_reg;

    // stage 2
    logic [PROD_W-1:0] a_next, hm_next, dd, cm_next;
    logic hneg_next, cneg_next;
    logic [PROD_W-1:0] a2_reg, hm2_reg, cm2_reg;
    logic hneg2_reg, cneg2_reg;

    // stage 3
    logic [HALF_W-1:0] h0, h1, a0, a1, c0, c1;
    logic hpos, cpos, done3_next;
    status_t st3_next;
    logic [PROD_W-1:0] hh00_reg, hh01_reg, hh11_reg, ac00_reg, ac01_reg, ac10_reg, ac11_reg;
    logic [PROD_W-1:0] a3_reg, hm3_reg;
    logic hneg3_reg, cneg3_reg, done3_reg;
    status_t st3_reg;

    // stage 4
    logic [WIDE_W-1:0] hsq_next, ac_next, hsq_reg, ac_reg;
    logic [PROD_W-1:0] a4_reg, hm4_reg;
    logic hneg4_reg, cneg4_reg, done4_reg;
    status_t st4_reg;

    // stage 5
    sq_t w5_next, w5_reg;
    logic vld5_reg;

    always_comb begin
        mdx     = mag(dx);
        mdy     = mag(dy);
        mvx     = mag(vx);
        mvy     = mag(vy);
        rr_prod = radius * radius;
    end

    always_comb begin
        a_next = vx2_reg + vy2_reg;
        if (pxn_reg == pyn_reg) begin
            hm_next   = px_reg + py_reg;
            hneg_next = pxn_reg;
        end else if (px_reg >= py_reg) begin
            hm_next   = px_reg - py_reg;
            hneg_next = pxn_reg;
        end else begin
            hm_next   = py_reg - px_reg;
            hneg_next = pyn_reg;
        end
        if (hm_next == '0) begin
            hneg_next = 1'b0;
        end
        dd        = dx2_reg + dy2_reg;
        cneg_next = dd < rr_reg;
        cm_next   = cneg_next ? (rr_reg - dd) : (dd - rr_reg);
    end

    always_comb begin
        h0   = hm2_reg[HALF_W-1:0];
        h1   = hm2_reg[PROD_W-1:HALF_W];
        a0   = a2_reg[HALF_W-1:0];
        a1   = a2_reg[PROD_W-1:HALF_W];
        c0   = cm2_reg[HALF_W-1:0];
        c1   = cm2_reg[PROD_W-1:HALF_W];
        hpos = !hneg2_reg && (hm2_reg != '0);
        cpos = !cneg2_reg && (cm2_reg != '0);
        done3_next = 1'b0;
        st3_next   = ST_HIT;
        if (a2_reg == '0) begin
            done3_next = 1'b1;
            st3_next   = ST_ZERO_VEL;
        end else if (hpos && cpos) begin
            done3_next = 1'b1;
            st3_next   = ST_BEHIND;
        end
    end

    always_comb begin
        hsq_next = {hh11_reg, {PROD_W{1'b0}}}
                 + ({{HALF_W{1'b0}}, hh01_reg, {HALF_W{1'b0}}} << 1)
                 + {{PROD_W{1'b0}}, hh00_reg};
        ac_next  = {ac11_reg, {PROD_W{1'b0}}}
                 + {{HALF_W{1'b0}}, ac01_reg, {HALF_W{1'b0}}}
                 + {{HALF_W{1'b0}}, ac10_reg, {HALF_W{1'b0}}}
                 + {{PROD_W{1'b0}}, ac00_reg};
    end

    always_comb begin
        w5_next.done   = done4_reg;
        w5_next.status = st4_reg;
        w5_next.hneg   = hneg4_reg;
        w5_next.hm     = hm4_reg;
        w5_next.a      = a4_reg;
        w5_next.rem    = '0;
        w5_next.root   = '0;
        if (cneg4_reg) begin
            w5_next.disc = hsq_reg + ac_reg;
        end else begin
            w5_next.disc = hsq_reg - ac_reg;
        end
        if (!done4_reg) begin
            if (!cneg4_reg && (hsq_reg < ac_reg)) begin
                w5_next.done   = 1'b1;
                w5_next.status = ST_NO_ROOT;
            end else if (!hneg4_reg && !cneg4_reg) begin
                w5_next.done   = 1'b1;
                w5_next.status = ST_NO_POS;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            vld5_reg <= 1'b0;
        end else if (en) begin
            vld_reg  <= {vld_reg[2:0], in_vld};
            vld5_reg <= vld_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vx2_reg <= mvx * mvx;
            vy2_reg <= mvy * mvy;
            dx2_reg <= mdx * mdx;
            dy2_reg <= mdy * mdy;
            rr_reg  <= {{(PROD_W-2*RAD_W){1'b0}}, rr_prod};
            px_reg  <= mvx * mdx;
            py_reg  <= mvy * mdy;
            pxn_reg <= vx[COORD_W-1] ^ dx[COORD_W-1];
            pyn_reg <= vy[COORD_W-1] ^ dy[COORD_W-1];

            a2_reg    <= a_next;
            hm2_reg   <= hm_next;
            cm2_reg   <= cm_next;
            hneg2_reg <= hneg_next;
            cneg2_reg <= cneg_next;

            hh00_reg  <= h0 * h0;
            hh01_reg  <= h0 * h1;
            hh11_reg  <= h1 * h1;
            ac00_reg  <= a0 * c0;
            ac01_reg  <= a0 * c1;
            ac10_reg  <= a1 * c0;
            ac11_reg  <= a1 * c1;
            a3_reg    <= a2_reg;
            hm3_reg   <= hm2_reg;
            hneg3_reg <= hneg2_reg;
            cneg3_reg <= cneg2_reg;
            done3_reg <= done3_next;
            st3_reg   <= st3_next;

            hsq_reg   <= hsq_next;
            ac_reg    <= ac_next;
            a4_reg    <= a3_reg;
            hm4_reg   <= hm3_reg;
            hneg4_reg <= hneg3_reg;
            cneg4_reg <= cneg3_reg;
            done4_reg <= done3_reg;
            st4_reg   <= st3_reg;

            w5_reg    <= w5_next;
        end
    end

    assign out_vld  = vld5_reg;
    assign out_word = w5_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mpch_sqrt_cell.sv =====
`default_nettype none
module mpch_sqrt_cell import mpch_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire logic in_vld,
    input  sq_t       in_word,
    output logic      out_vld,
    output sq_t       out_word
);

    logic [SQREM_W+1:0] rem2, trial;
    sq_t  w_next, w_reg;
    logic vld_reg;

    // one root bit per cell: bring down two radicand bits, try root*4+1
    always_comb begin
        rem2   = {in_word.rem, in_word.disc[WIDE_W-1 -: 2]};
        trial  = {{(SQREM_W-ROOT_W){1'b0}}, in_word.root, 2'b01};
        w_next = in_word;
        w_next.disc = {in_word.disc[WIDE_W-3:0], 2'b00};
        if (rem2 >= trial) begin
            w_next.rem  = SQREM_W'(rem2 - trial);
            w_next.root = {in_word.root[ROOT_W-2:0], 1'b1};
        end else begin
            w_next.rem  = SQREM_W'(rem2);
            w_next.root = {in_word.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg <= w_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_word = w_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mpch_div_cell.sv =====
`default_nettype none
module mpch_div_cell import mpch_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire logic in_vld,
    input  dv_t       in_word,
    output logic      out_vld,
    output dv_t       out_word
);

    logic [PROD_W:0] rem2;
    dv_t  w_next, w_reg;
    logic vld_reg;

    // one quotient bit per cell, restoring
    always_comb begin
        rem2   = {in_word.rem, in_word.bits[TIME_W-1]};
        w_next = in_word;
        w_next.bits = {in_word.bits[TIME_W-2:0], 1'b0};
        if (rem2 >= {1'b0, in_word.a}) begin
            w_next.rem  = PROD_W'(rem2 - {1'b0, in_word.a});
            w_next.quot = {in_word.quot[TIME_W-2:0], 1'b1};
        end else begin
            w_next.rem  = rem2[PROD_W-1:0];
            w_next.quot = {in_word.quot[TIME_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg <= w_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_word = w_reg;

endmodule
`default_nettype wire

// ===== rtl/core/moving_point_circle_hit_time.sv =====
// Pipeline from accepted input word to result word: 5 setup stages, 48 square-root
// cells, 1 numerator stage, 32 divider cells, 1 output register.
// Throughput: one word per cycle; the whole pipeline holds while the output
// register is full and m_ready is low.
// Reset: synchronous, active low aresetn clears all valid bits; no data state.
`default_nettype none
`include "moving_point_circle_hit_time_assert.svh"
module moving_point_circle_hit_time import mpch_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [COORD_W-1:0] s_dx,
    input  wire logic [COORD_W-1:0] s_dy,
    input  wire logic [COORD_W-1:0] s_vx,
    input  wire logic [COORD_W-1:0] s_vy,
    input  wire logic [RAD_W-1:0]   s_radius,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_status,
    output logic [TIME_W-1:0]       m_hit_time
);

    logic en;
    logic sq_vld [0:SQ_CELLS];
    sq_t  sq_w   [0:SQ_CELLS];
    logic dv_vld [0:DIV_CELLS];
    dv_t  dv_w   [0:DIV_CELLS];

    logic [NUM_W-1:0] num;
    dv_t  dv0_next, dv0_reg;
    logic dv0_vld_reg;

    logic m_valid_reg;
    logic [2:0] m_status_reg, m_status_next;
    logic [TIME_W-1:0] m_time_reg, m_time_next;

    dv_t last;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    mpch_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_valid),
        .dx       (s_dx),
        .dy       (s_dy),
        .vx       (s_vx),
        .vy       (s_vy),
        .radius   (s_radius),
        .out_vld  (sq_vld[0]),
        .out_word (sq_w[0])
    );

    for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
        mpch_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_vld   (sq_vld[i]),
            .in_word  (sq_w[i]),
            .out_vld  (sq_vld[i+1]),
            .out_word (sq_w[i+1])
        );
    end

    // numerator (-h + root), scaled by 2^16 through the shifted-in bits
    always_comb begin
        if (sq_w[SQ_CELLS].hneg) begin
            num = {1'b0, sq_w[SQ_CELLS].root} + {1'b0, sq_w[SQ_CELLS].hm};
        end else begin
            num = {1'b0, sq_w[SQ_CELLS].root} - {1'b0, sq_w[SQ_CELLS].hm};
        end
        dv0_next.done   = sq_w[SQ_CELLS].done;
        dv0_next.status = sq_w[SQ_CELLS].status;
        dv0_next.a      = sq_w[SQ_CELLS].a;
        dv0_next.sat    = {{(PROD_W-(NUM_W-TIME_FRAC)){1'b0}}, num[NUM_W-1:TIME_FRAC]}
                          >= sq_w[SQ_CELLS].a;
        dv0_next.rem    = {{(PROD_W-(NUM_W-TIME_FRAC)){1'b0}}, num[NUM_W-1:TIME_FRAC]};
        dv0_next.bits   = {num[TIME_FRAC-1:0], {(TIME_W-TIME_FRAC){1'b0}}};
        dv0_next.quot   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv0_vld_reg <= 1'b0;
        end else if (en) begin
            dv0_vld_reg <= sq_vld[SQ_CELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv0_reg <= dv0_next;
        end
    end

    assign dv_vld[0] = dv0_vld_reg;
    assign dv_w[0]   = dv0_reg;

    for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
        mpch_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_vld   (dv_vld[j]),
            .in_word  (dv_w[j]),
            .out_vld  (dv_vld[j+1]),
            .out_word (dv_w[j+1])
        );
    end

    assign last = dv_w[DIV_CELLS];

    always_comb begin
        if (last.done) begin
            m_status_next = last.status;
            m_time_next   = '0;
        end else begin
            m_status_next = ST_HIT;
            m_time_next   = last.sat ? {TIME_W{1'b1}} : last.quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_vld[DIV_CELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_status_reg <= m_status_next;
            m_time_reg   <= m_time_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_hit_time = m_time_reg;

    `MPCH_ASSERT_IMP(a_time_zero_on_miss, m_valid && (m_status != ST_HIT), m_hit_time == '0, "hit_time nonzero without a hit")
    `MPCH_ASSERT_IMP(a_div_rem_below_a, dv_vld[DIV_CELLS] && !last.done && !last.sat, last.rem < last.a, "divider remainder out of range")
    `MPCH_ASSERT_ALWAYS(a_out_empty_after_reset, $past(!aresetn), !m_valid, "result word valid right after reset")

endmodule
`default_nettype wire

// ===== bench/hit_time_checker.sv =====
`timescale 1ns / 1ps
module hit_time_checker import mpch_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [COORD_W-1:0] s_dx,
    input  wire logic [COORD_W-1:0] s_dy,
    input  wire logic [COORD_W-1:0] s_vx,
    input  wire logic [COORD_W-1:0] s_vy,
    input  wire logic [RAD_W-1:0]   s_radius,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic [2:0]         m_status,
    input  wire logic [TIME_W-1:0]  m_hit_time,
    output int                      fail_count,
    output int                      pending,
    output int                      hit_count
);

    typedef struct {
        status_t          status;
        logic [TIME_W-1:0] hit_time;
    } contact_t;

    contact_t contact_q[$];

    // exact integer solution of the contact time
    function automatic contact_t predict_contact(
        logic signed [COORD_W-1:0] dx, logic signed [COORD_W-1:0] dy,
        logic signed [COORD_W-1:0] vx, logic signed [COORD_W-1:0] vy,
        logic [RAD_W-1:0] r);
        contact_t res;
        logic signed [127:0] a, h, c, disc, num, q;
        logic [127:0] s, cand;
        res.status = ST_HIT;
        res.hit_time = '0;
        a = 128'(vx) * vx + 128'(vy) * vy;
        h = 128'(vx) * dx + 128'(vy) * dy;
        c = 128'(dx) * dx + 128'(dy) * dy
            - 128'($signed({1'b0, r})) * $signed({1'b0, r});
        if (a == 0) begin
            res.status = ST_ZERO_VEL;
            return res;
        end
        if (h > 0 && c > 0) begin
            res.status = ST_BEHIND;
            return res;
        end
        disc = h * h - a * c;
        if (disc < 0) begin
            res.status = ST_NO_ROOT;
            return res;
        end
        if (h >= 0 && c >= 0) begin
            res.status = ST_NO_POS;
            return res;
        end
        s = 0;
        for (int i = 63; i >= 0; i--) begin
            cand = s | (128'd1 << i);
            if (cand * cand <= disc) s = cand;
        end
        num = ($signed(s) - h) <<< TIME_FRAC;
        q = num / a;
        res.hit_time = (q > 128'sh0FFFFFFFF) ? '1 : q[TIME_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        hit_count = 0;
    end

    assign pending = contact_q.size();

    always @(posedge aclk) begin
        contact_t want;
        if (aresetn && s_valid && s_ready)
            contact_q.push_back(predict_contact(s_dx, s_dy, s_vx, s_vy, s_radius));
        if (aresetn && m_valid && m_ready) begin
            if (contact_q.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = contact_q.pop_front();
                if (m_status == ST_HIT) hit_count++;
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                        m_status, want.status));
                if (m_hit_time !== want.hit_time)
                    report_mismatch($sformatf("hit_time %h, expected %h",
                        m_hit_time, want.hit_time));
            end
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb import mpch_pkg::*;;

    localparam int LATENCY = 87;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 1330;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [COORD_W-1:0] s_dx, s_dy, s_vx, s_vy;
    logic [RAD_W-1:0]   s_radius;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_status;
    logic [TIME_W-1:0]  m_hit_time;
    int                 fail_count, pending, hit_count;
    int                 send_idle, recv_stall;
    int                 words_sent;
    int                 quiet_cycles;

    moving_point_circle_hit_time u_dut (.*);

    hit_time_checker u_chk (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // receiver stalls
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall);

    // watchdog on accepted words
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // drop valid only while idling so back-to-back words see one update per edge
    task automatic send_word(input logic [COORD_W-1:0] dx, input logic [COORD_W-1:0] dy,
                             input logic [COORD_W-1:0] vx, input logic [COORD_W-1:0] vy,
                             input logic [RAD_W-1:0] r);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_dx     <= dx;
        s_dy     <= dy;
        s_vx     <= vx;
        s_vy     <= vy;
        s_radius <= r;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(input int mode);
        logic [COORD_W-1:0] v;
        case (mode)
            0: v = $urandom;
            1: v = COORD_W'($signed($urandom_range(4095)) - 2048);
            default: v = COORD_W'($signed($urandom_range(131071)) - 65536);
        endcase
        return v;
    endfunction

    task automatic random_word();
        int mode;
        logic [COORD_W-1:0] dx, dy, vx, vy;
        logic [RAD_W-1:0] r;
        mode = $urandom_range(2);
        dx = pick_coord(mode);
        dy = pick_coord(mode);
        vx = pick_coord($urandom_range(2));
        vy = pick_coord($urandom_range(2));
        case ($urandom_range(5))
            0: r = $urandom;
            1: r = $urandom_range(200);
            default: begin
                // radius near the distance so the point is close to the rim
                r = RAD_W'($sqrt(real'($signed(dx)) ** 2 + real'($signed(dy)) ** 2)
                    * (0.5 + $urandom_range(100) / 100.0));
            end
        endcase
        if ($urandom_range(40) == 0) begin
            vx = '0;
            vy = '0;
        end else if ($urandom_range(3) == 0) begin
            // head roughly toward the center
            vx = -dx >>> $urandom_range(6);
            vy = -dy >>> $urandom_range(6);
        end
        send_word(dx, dy, vx, vy, r);
    endtask

    localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_dx = '0; s_dy = '0; s_vx = '0; s_vy = '0; s_radius = '0;
        m_ready    = 1'b0;
        send_idle  = 0;
        recv_stall = 0;
        words_sent = 0;
        quiet_cycles = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero velocity, behind, no root, no positive root, hits, extremes
        send_word('0, '0, '0, '0, '0);
        send_word(24'd2560, '0, '0, '0, 23'd256);
        send_word(24'd2560, '0, 24'd256, '0, 23'd256);
        send_word(24'd2560, 24'd2560, -24'd256, '0, 23'd256);
        send_word(24'd2560, '0, '0, 24'd256, 23'd256);
        send_word(24'd2560, '0, -24'd256, '0, 23'd256);
        send_word('0, '0, 24'd256, '0, 23'd256);
        send_word(24'd256, '0, 24'd256, '0, 23'd256);
        send_word(24'd256, '0, -24'd256, '0, 23'd256);
        send_word(C_MAX, C_MAX, C_MIN, C_MIN, '1);
        send_word(C_MIN, C_MIN, C_MAX, C_MAX, '1);
        send_word(C_MAX, '0, 24'd1, '0, '0);
        send_word(C_MAX, '0, -24'd1, '0, '0);
        send_word(C_MIN, '0, 24'd1, '0, 23'd1);
        send_word('0, '0, 24'd1, '0, '1);
        send_word('0, '0, C_MAX, C_MAX, 23'd1);
        send_word(24'd1, '0, -24'd1, '0, '0);
        send_word('1, '1, '1, '1, '1);
        send_word(C_MAX, C_MIN, C_MIN, C_MAX, '1);
        send_word(24'h555555, 24'hAAAAAA, 24'h2AAAAA, 24'hD55555, 23'h2AAAAA);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ((i * 5) / RANDOM_ITEMS)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 68; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 68; end
                3: begin send_idle = 12; recv_stall = 12; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            random_word();
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("Sent %0d words across idle and stall phases; %0d came back as hits.",
                 words_sent, hit_count);
        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
